[src/lrgd_pkg.sv]
// shared types, constants and helpers of the linear regression trainer
package lrgd_pkg;

    localparam int LRGD_MAX_SAMPLES = 64;
    localparam int DATA_WIDTH       = 32;
    localparam int MAX_FEATURES     = 4;
    localparam int FRAC_BITS        = 16;
    localparam int LR_BITS          = 24;
    localparam int EPOCH_W          = 16;
    localparam int FEAT_CFG_W       = 3;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 24;
    localparam int COL_W            = $clog2(MAX_FEATURES);
    localparam int J_W              = $clog2(MAX_FEATURES + 2);
    localparam int PROD_W           = 2 * DATA_WIDTH;
    localparam int PSH_W            = PROD_W - FRAC_BITS;
    localparam int ACC_W            = PSH_W + 3;
    localparam int STEP_W           = PROD_W - LR_BITS;

    localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EPOCH_COUNT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FEATURES      = 2'd2;

    localparam logic OPC_SAMPLE  = 1'b0;
    localparam logic OPC_WEIGHTS = 1'b1;

    localparam logic [CFG_DATA_W-1:0] LR_RESET     = 24'd16777;
    localparam logic [EPOCH_W-1:0]    EPOCH_RESET  = 16'd10000;
    localparam logic [FEAT_CFG_W-1:0] FEAT_RESET   = 3'd2;

    typedef logic signed [DATA_WIDTH-1:0] t_data;

    typedef enum logic [1:0] {
        KIND_WEIGHT = 2'd0,
        KIND_BIAS   = 2'd1,
        KIND_MSE    = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_CLR,
        OP_READ,
        OP_PMUL,
        OP_PACC,
        OP_ERR_TRAIN,
        OP_ERR_MSE,
        OP_GMUL,
        OP_GACC,
        OP_EMUL,
        OP_EACC,
        OP_DSTART_G,
        OP_DSTART_MSE,
        OP_SMUL,
        OP_SUPD
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [COL_W-1:0] col;
        logic             bias;
        t_kind            kind;
        logic             wr_sample;
        logic             set_wts;
    } t_cmd;

    typedef struct packed {
        t_data                                  label;
        logic [MAX_FEATURES-1:0][DATA_WIDTH-1:0] feat;
    } t_row;

    localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
    localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

    // clamp to the signed data range
    function automatic t_data sat_dw(input logic signed [63:0] v);
        t_data r;
        if (v > SAT_HI) begin
            r = t_data'(SAT_HI);
        end else if (v < SAT_LO) begin
            r = t_data'(SAT_LO);
        end else begin
            r = t_data'(v);
        end
        return r;
    endfunction

endpackage

[src/linear_regression_gd_trainer_core.sv]
// top level of the full-batch gradient descent linear regression trainer
// Requests with opcode 0 store one training sample (four Q16.16 features and a label), and
// requests with opcode 1 load the start weights and bias; a sample request flagged last starts
// training on the stored samples, and no request is taken until all results are delivered.
// Training time is set by one shared 32x32 multiplier and one radix-2 divider; after the last
// epoch one error pass follows. Results then come out one per cycle while the consumer is
// ready: k weights (one per feature column in use), the bias, then the mean squared error
// flagged as the last result. Trained weights and bias stay as the start point of the next
// run. Configuration registers: 0 learning rate (Q0.24), 1 epoch count, 2 feature columns in
// use (clamped to 1..4); write them only while idle.
module linear_regression_gd_trainer_core #(
    parameter int MAX_SAMPLES = lrgd_pkg::LRGD_MAX_SAMPLES
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write port
    input  logic                               i_cfg_we,
    input  logic [lrgd_pkg::CFG_IDX_W-1:0]     i_cfg_addr,
    input  logic [lrgd_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // request channel
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_opcode,
    input  lrgd_pkg::t_data                    i_value_0,
    input  lrgd_pkg::t_data                    i_value_1,
    input  lrgd_pkg::t_data                    i_value_2,
    input  lrgd_pkg::t_data                    i_value_3,
    input  lrgd_pkg::t_data                    i_target,
    input  logic                               i_last_sample,
    // result channel
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [1:0]                         o_result_kind,
    output logic [1:0]                         o_weight_index,
    output lrgd_pkg::t_data                    o_result_value,
    output logic                               o_last_result
);
    import lrgd_pkg::*;

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int A_W   = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

    // configuration registers
    logic [CFG_DATA_W-1:0] r_lr;
    logic [EPOCH_W-1:0]    r_epochs;
    logic [FEAT_CFG_W-1:0] r_feat;

    t_cmd             cmd;
    logic [A_W-1:0]   addr;
    logic [CNT_W-1:0] count;
    logic             div_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lr     <= LR_RESET;
            r_epochs <= EPOCH_RESET;
            r_feat   <= FEAT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_LEARNING_RATE: r_lr     <= i_cfg_data;
                CFG_EPOCH_COUNT:   r_epochs <= i_cfg_data[EPOCH_W-1:0];
                CFG_FEATURES:      r_feat   <= i_cfg_data[FEAT_CFG_W-1:0];
                default: ;     // unmapped index, write dropped
            endcase
        end
    end

    // sequencer: owns sample count, loop counters and the handshakes
    lrgd_ctrl #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_opcode       (i_opcode),
        .i_last_sample  (i_last_sample),
        .o_in_ready     (o_in_ready),
        .i_epochs       (r_epochs),
        .i_features     (r_feat),
        .i_div_busy     (div_busy),
        .o_cmd          (cmd),
        .o_addr         (addr),
        .o_count        (count),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_result_kind  (o_result_kind),
        .o_weight_index (o_weight_index),
        .o_last_result  (o_last_result)
    );

    // datapath: sample memory, multiplier, gradient sums, divider, parameters
    lrgd_datapath #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_addr         (addr),
        .i_count        (count),
        .i_value_0      (i_value_0),
        .i_value_1      (i_value_1),
        .i_value_2      (i_value_2),
        .i_value_3      (i_value_3),
        .i_target       (i_target),
        .i_lr           (r_lr),
        .o_div_busy     (div_busy),
        .o_result_value (o_result_value)
    );

    // results never overlap with taking new requests
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("result pending while requests are taken");

    // the divider is only started when idle
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.op == OP_DSTART_G || cmd.op == OP_DSTART_MSE) |-> !div_busy)
        else $error("divider restarted while busy");

    // after the final result the block is ready again
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_last_result) |=> (o_in_ready && count == '0))
        else $error("run did not close cleanly");

    // the final result is the error value
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last_result) |-> (o_result_kind == KIND_MSE))
        else $error("last result is not the error value");

endmodule

[src/lrgd_div.sv]
// radix-2 restoring divider, truncating toward zero, saturated quotient
module lrgd_div #(
    parameter int DIV_W = 56,
    parameter int DEN_W = 7
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [DIV_W-1:0]  i_dividend,
    input  logic        [DEN_W-1:0]  i_divisor,
    output logic                     o_busy,
    output lrgd_pkg::t_data          o_quot
);
    import lrgd_pkg::*;

    localparam int CW = $clog2(DIV_W);
    localparam logic [DIV_W-1:0] LIM = DIV_W'(1) << (DATA_WIDTH - 1);

    logic             r_busy;
    logic [CW-1:0]    r_cnt;
    logic [DIV_W-1:0] r_q;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic             r_neg;

    logic [DEN_W:0]   trial;
    logic             fits;
    logic [DIV_W-1:0] mag;

    assign trial = {r_rem, r_q[DIV_W-1]};
    assign fits  = trial >= {1'b0, r_den};
    assign mag   = i_dividend[DIV_W-1] ? DIV_W'(-i_dividend) : DIV_W'(i_dividend);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CW'(1);
            if (r_cnt == CW'(DIV_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= mag;
            r_rem <= '0;
            r_den <= i_divisor;
            r_neg <= i_dividend[DIV_W-1];
        end else if (r_busy) begin
            r_q   <= {r_q[DIV_W-2:0], fits};
            r_rem <= fits ? DEN_W'(trial - {1'b0, r_den}) : DEN_W'(trial);
        end
    end

    always_comb begin
        if (r_neg) begin
            o_quot = (r_q > LIM) ? t_data'(SAT_LO) : t_data'(-r_q);
        end else begin
            o_quot = (r_q > LIM - DIV_W'(1)) ? t_data'(SAT_HI) : t_data'(r_q);
        end
    end

    assign o_busy = r_busy;

endmodule

[src/lrgd_datapath.sv]
// sample store, multiply-accumulate datapath, gradient sums and weight update
module lrgd_datapath #(
    parameter int MAX_SAMPLES = lrgd_pkg::LRGD_MAX_SAMPLES
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  lrgd_pkg::t_cmd                             i_cmd,
    input  logic [((MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1)-1:0] i_addr,
    input  logic [$clog2(MAX_SAMPLES + 1)-1:0]         i_count,
    input  lrgd_pkg::t_data                            i_value_0,
    input  lrgd_pkg::t_data                            i_value_1,
    input  lrgd_pkg::t_data                            i_value_2,
    input  lrgd_pkg::t_data                            i_value_3,
    input  lrgd_pkg::t_data                            i_target,
    input  logic [lrgd_pkg::CFG_DATA_W-1:0]            i_lr,
    output logic                                       o_div_busy,
    output lrgd_pkg::t_data                            o_result_value
);
    import lrgd_pkg::*;

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W = PSH_W + CNT_W;
    localparam int DIV_W = SUM_W + 1;

    t_row                     r_mem [MAX_SAMPLES];
    t_row                     r_row;
    t_data                    r_w [MAX_FEATURES];
    t_data                    r_bias;
    logic signed [ACC_W-1:0]  r_acc;
    t_data                    r_err;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [SUM_W-1:0]  r_gsum [MAX_FEATURES+1];
    logic signed [SUM_W-1:0]  r_mse_sum;

    t_data                    vin [4];
    t_row                     wr_row;
    logic signed [PSH_W-1:0]  prod_sh;
    logic signed [STEP_W-1:0] step;
    t_data                    pred;
    t_data                    label;
    logic signed [DATA_WIDTH:0] diff;
    t_data                    err_n;
    t_data                    old_v;
    t_data                    upd;
    t_data                    mul_a;
    t_data                    mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic [J_W-1:0]           gsel;
    logic signed [DIV_W-1:0]  dividend;
    logic                     div_start;
    t_data                    div_q;

    assign vin[0] = i_value_0;
    assign vin[1] = i_value_1;
    assign vin[2] = i_value_2;
    assign vin[3] = i_value_3;

    always_comb begin
        wr_row.label = i_target;
        for (int j = 0; j < MAX_FEATURES; j++) begin
            wr_row.feat[j] = vin[j % 4];
        end
    end

    // sample store
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_sample) begin
            r_mem[i_addr] <= wr_row;
        end
        if (i_cmd.op == OP_READ) begin
            r_row <= r_mem[i_addr];
        end
    end

    assign prod_sh = r_prod[PROD_W-1:FRAC_BITS];
    assign step    = r_prod[PROD_W-1:LR_BITS];
    assign pred    = sat_dw(64'(r_acc));
    assign label   = r_row.label;
    // error pass takes label minus prediction, saturation is not symmetric
    assign diff    = (i_cmd.op == OP_ERR_MSE)
                   ? $signed({label[DATA_WIDTH-1], label}) - $signed({pred[DATA_WIDTH-1], pred})
                   : $signed({pred[DATA_WIDTH-1], pred}) - $signed({label[DATA_WIDTH-1], label});
    assign err_n   = sat_dw(64'(diff));
    assign old_v   = i_cmd.bias ? r_bias : r_w[i_cmd.col];
    assign upd     = sat_dw(64'(old_v) - 64'(step));

    always_comb begin
        case (i_cmd.op)
            OP_PMUL: begin
                mul_a = r_w[i_cmd.col];
                mul_b = $signed(r_row.feat[i_cmd.col]);
            end
            OP_GMUL: begin
                mul_a = $signed(r_row.feat[i_cmd.col]);
                mul_b = r_err;
            end
            OP_EMUL: begin
                mul_a = r_err;
                mul_b = r_err;
            end
            OP_SMUL: begin
                mul_a = div_q;
                mul_b = $signed({{(DATA_WIDTH - LR_BITS){1'b0}}, i_lr});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign gsel      = i_cmd.bias ? J_W'(MAX_FEATURES) : J_W'(i_cmd.col);
    assign div_start = (i_cmd.op == OP_DSTART_G) || (i_cmd.op == OP_DSTART_MSE);
    assign dividend  = (i_cmd.op == OP_DSTART_MSE) ? DIV_W'(r_mse_sum) : {r_gsum[gsel], 1'b0};

    lrgd_div #(
        .DIV_W (DIV_W),
        .DEN_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend),
        .i_divisor  (i_count),
        .o_busy     (o_div_busy),
        .o_quot     (div_q)
    );

    // model parameters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < MAX_FEATURES; j++) begin
                r_w[j] <= '0;
            end
            r_bias <= '0;
        end else if (i_cmd.set_wts) begin
            for (int j = 0; j < MAX_FEATURES; j++) begin
                r_w[j] <= vin[j % 4];
            end
            r_bias <= i_target;
        end else if (i_cmd.op == OP_SUPD) begin
            if (i_cmd.bias) begin
                r_bias <= upd;
            end else begin
                r_w[i_cmd.col] <= upd;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_CLR: begin
                for (int j = 0; j <= MAX_FEATURES; j++) begin
                    r_gsum[j] <= '0;
                end
                r_mse_sum <= '0;
            end
            OP_READ:      r_acc <= ACC_W'(r_bias);
            OP_PMUL,
            OP_GMUL,
            OP_EMUL,
            OP_SMUL:      r_prod <= mul_p;
            OP_PACC:      r_acc <= r_acc + ACC_W'(prod_sh);
            OP_ERR_TRAIN: begin
                r_err <= err_n;
                r_gsum[MAX_FEATURES] <= r_gsum[MAX_FEATURES] + SUM_W'(err_n);
            end
            OP_ERR_MSE:   r_err <= err_n;
            OP_GACC:      r_gsum[J_W'(i_cmd.col)] <= r_gsum[J_W'(i_cmd.col)] + SUM_W'(prod_sh);
            OP_EACC:      r_mse_sum <= r_mse_sum + SUM_W'(prod_sh);
            default: ;
        endcase
    end

    always_comb begin
        unique case (i_cmd.kind)
            KIND_WEIGHT: o_result_value = r_w[i_cmd.col];
            KIND_BIAS:   o_result_value = r_bias;
            KIND_MSE:    o_result_value = div_q;
            default:     o_result_value = '0;
        endcase
    end

endmodule

[src/lrgd_ctrl.sv]
// sequencer for loading, training epochs, final error pass and result output
module lrgd_ctrl #(
    parameter int MAX_SAMPLES = lrgd_pkg::LRGD_MAX_SAMPLES
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_in_valid,
    input  logic                                       i_opcode,
    input  logic                                       i_last_sample,
    output logic                                       o_in_ready,
    input  logic [lrgd_pkg::EPOCH_W-1:0]               i_epochs,
    input  logic [lrgd_pkg::FEAT_CFG_W-1:0]            i_features,
    input  logic                                       i_div_busy,
    output lrgd_pkg::t_cmd                             o_cmd,
    output logic [((MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1)-1:0] o_addr,
    output logic [$clog2(MAX_SAMPLES + 1)-1:0]         o_count,
    output logic                                       o_out_valid,
    input  logic                                       i_out_ready,
    output logic [1:0]                                 o_result_kind,
    output logic [1:0]                                 o_weight_index,
    output logic                                       o_last_result
);
    import lrgd_pkg::*;

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int A_W   = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

    typedef enum logic [14:0] {
        S_IDLE   = 15'h0001,
        S_EPOCH  = 15'h0002,
        S_READ   = 15'h0004,
        S_PMUL   = 15'h0008,
        S_PACC   = 15'h0010,
        S_ERR    = 15'h0020,
        S_GMUL   = 15'h0040,
        S_GACC   = 15'h0080,
        S_EMUL   = 15'h0100,
        S_EACC   = 15'h0200,
        S_DSTART = 15'h0400,
        S_DWAIT  = 15'h0800,
        S_SMUL   = 15'h1000,
        S_SUPD   = 15'h2000,
        S_EMIT   = 15'h4000
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic [J_W-1:0]     r_j, n_j;
    logic [EPOCH_W-1:0] r_epoch, n_epoch;
    logic               r_mse, n_mse;

    logic [J_W-1:0]     k;
    logic               last_col;
    logic               last_idx;
    t_kind              kind;

    always_comb begin
        if (i_features == '0) begin
            k = J_W'(1);
        end else if (i_features > FEAT_CFG_W'(MAX_FEATURES)) begin
            k = J_W'(MAX_FEATURES);
        end else begin
            k = J_W'(i_features);
        end
    end

    assign last_col = (r_j == k - J_W'(1));
    assign last_idx = ((r_idx + CNT_W'(1)) == r_count);

    always_comb begin
        if (r_j < k) begin
            kind = KIND_WEIGHT;
        end else if (r_j == k) begin
            kind = KIND_BIAS;
        end else begin
            kind = KIND_MSE;
        end
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_idx   = r_idx;
        n_j     = r_j;
        n_epoch = r_epoch;
        n_mse   = r_mse;

        o_cmd           = '0;
        o_cmd.op        = OP_NOP;
        o_cmd.col       = r_j[COL_W-1:0];
        o_cmd.bias      = (r_j == k);
        o_cmd.kind      = kind;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_opcode == OPC_WEIGHTS) begin
                        o_cmd.set_wts = 1'b1;
                    end else begin
                        if (r_count < CNT_W'(MAX_SAMPLES)) begin
                            o_cmd.wr_sample = 1'b1;
                            n_count         = r_count + CNT_W'(1);
                        end
                        if (i_last_sample) begin
                            n_j     = '0;
                            n_epoch = '0;
                            n_state = S_EPOCH;
                        end
                    end
                end
            end
            S_EPOCH: begin
                o_cmd.op = OP_CLR;
                n_idx    = '0;
                n_j      = '0;
                n_mse    = (r_epoch == i_epochs);
                n_state  = S_READ;
            end
            S_READ: begin
                o_cmd.op = OP_READ;
                n_j      = '0;
                n_state  = S_PMUL;
            end
            S_PMUL: begin
                o_cmd.op = OP_PMUL;
                n_state  = S_PACC;
            end
            S_PACC: begin
                o_cmd.op = OP_PACC;
                if (last_col) begin
                    n_j     = '0;
                    n_state = S_ERR;
                end else begin
                    n_j     = r_j + J_W'(1);
                    n_state = S_PMUL;
                end
            end
            S_ERR: begin
                o_cmd.op = r_mse ? OP_ERR_MSE : OP_ERR_TRAIN;
                n_state  = r_mse ? S_EMUL : S_GMUL;
            end
            S_GMUL: begin
                o_cmd.op = OP_GMUL;
                n_state  = S_GACC;
            end
            S_GACC: begin
                o_cmd.op = OP_GACC;
                if (!last_col) begin
                    n_j     = r_j + J_W'(1);
                    n_state = S_GMUL;
                end else if (last_idx) begin
                    n_j     = '0;
                    n_state = S_DSTART;
                end else begin
                    n_idx   = r_idx + CNT_W'(1);
                    n_state = S_READ;
                end
            end
            S_EMUL: begin
                o_cmd.op = OP_EMUL;
                n_state  = S_EACC;
            end
            S_EACC: begin
                o_cmd.op = OP_EACC;
                if (last_idx) begin
                    n_j     = '0;
                    n_state = S_DSTART;
                end else begin
                    n_idx   = r_idx + CNT_W'(1);
                    n_state = S_READ;
                end
            end
            S_DSTART: begin
                o_cmd.op = r_mse ? OP_DSTART_MSE : OP_DSTART_G;
                n_state  = S_DWAIT;
            end
            S_DWAIT: begin
                if (!i_div_busy) begin
                    if (r_mse) begin
                        n_j     = '0;
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_SMUL;
                    end
                end
            end
            S_SMUL: begin
                o_cmd.op = OP_SMUL;
                n_state  = S_SUPD;
            end
            S_SUPD: begin
                o_cmd.op = OP_SUPD;
                if (r_j == k) begin
                    n_epoch = r_epoch + EPOCH_W'(1);
                    n_state = S_EPOCH;
                end else begin
                    n_j     = r_j + J_W'(1);
                    n_state = S_DSTART;
                end
            end
            S_EMIT: begin
                if (i_out_ready) begin
                    if (kind == KIND_MSE) begin
                        n_count = '0;
                        n_epoch = '0;
                        n_j     = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_j = r_j + J_W'(1);
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_idx   <= '0;
            r_j     <= '0;
            r_epoch <= '0;
            r_mse   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
            r_j     <= n_j;
            r_epoch <= n_epoch;
            r_mse   <= n_mse;
        end
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = (r_state == S_EMIT);
    assign o_addr         = (r_state == S_IDLE) ? r_count[A_W-1:0] : r_idx[A_W-1:0];
    assign o_count        = r_count;
    assign o_result_kind  = kind;
    assign o_weight_index = (kind == KIND_WEIGHT) ? 2'(r_j[COL_W-1:0]) : 2'd0;
    assign o_last_result  = (kind == KIND_MSE);

endmodule
